>>> rtl/ppcdec_pkg.sv
// Package for the PowerPC instruction decoder: payload structs, status codes,
// mnemonic codes and fixed instruction words. No dependencies.
package ppcdec_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  mnemonic;
    logic        record_flag;
    logic        overflow_flag;
    logic        link_flag;
    logic        absolute_flag;
    logic [4:0]  field_d;
    logic [4:0]  field_a;
    logic [4:0]  field_b;
    logic [4:0]  field_c;
    logic [4:0]  field_e;
    logic [31:0] value;
  } out_item_t;

  // Fixed instruction words
  localparam logic [31:0] W_NOP     = 32'h6000_0000;
  localparam logic [31:0] W_SC      = 32'h4400_0002;
  localparam logic [31:0] W_RFI     = 32'h4C00_0064;
  localparam logic [31:0] W_ISYNC   = 32'h4C00_012C;
  localparam logic [31:0] W_BLR     = 32'h4E80_0020;
  localparam logic [31:0] W_BLRL    = 32'h4E80_0021;
  localparam logic [31:0] W_BCTR    = 32'h4E80_0420;
  localparam logic [31:0] W_BCTRL   = 32'h4E80_0421;
  localparam logic [31:0] W_TLBSYNC = 32'h7C00_046C;
  localparam logic [31:0] W_SYNC    = 32'h7C00_04AC;
  localparam logic [31:0] W_EIEIO   = 32'h7C00_06AC;
  localparam logic [9:0]  XO_DCBZ   = 10'd1014;

  // Mnemonic codes (base codes for ranges)
  localparam logic [7:0] MN_NONE = 8'd0;
  localparam logic [7:0] MN_TWI = 8'd1, MN_DCBZ_L = 8'd2, MN_MULLI = 8'd3;
  localparam logic [7:0] MN_SUBFIC = 8'd4, MN_CMPLWI = 8'd5, MN_CMPLDI = 8'd6;
  localparam logic [7:0] MN_CMPWI = 8'd7, MN_CMPDI = 8'd8, MN_SC = 8'd9;
  localparam logic [7:0] MN_SUBIC = 8'd10, MN_ADDIC = 8'd14, MN_LI = 8'd18;
  localparam logic [7:0] MN_LIS = 8'd19, MN_BGE = 8'd20, MN_BLT = 8'd24;
  localparam logic [7:0] MN_BC = 8'd28, MN_B = 8'd29, MN_RFI = 8'd30;
  localparam logic [7:0] MN_ISYNC = 8'd31, MN_BLR = 8'd32, MN_BLRL = 8'd33;
  localparam logic [7:0] MN_BCTR = 8'd34, MN_BCTRL = 8'd35, MN_CRNOR = 8'd36;
  localparam logic [7:0] MN_CRANDC = 8'd37, MN_CRXOR = 8'd38, MN_CRCLR = 8'd39;
  localparam logic [7:0] MN_CRNAND = 8'd40, MN_CRAND = 8'd41, MN_CREQV = 8'd42;
  localparam logic [7:0] MN_CRORC = 8'd43, MN_CROR = 8'd44, MN_RLWIMI = 8'd45;
  localparam logic [7:0] MN_NOP = 8'd47, MN_ORI = 8'd48, MN_TLBSYNC = 8'd54;
  localparam logic [7:0] MN_SYNC = 8'd55, MN_EIEIO = 8'd56;
  localparam logic [7:0] MN_MTXER = 8'd88, MN_MR = 8'd94, MN_OR = 8'd95;
  localparam logic [7:0] MN_MFTBL = 8'd101, MN_MFTBU = 8'd102;
  localparam logic [7:0] MN_MFXER = 8'd104, MN_NOT = 8'd124, MN_NOR = 8'd125;
  localparam logic [7:0] MN_CMPLW = 8'd132, MN_CMPLD = 8'd133;
  localparam logic [7:0] MN_CMPW = 8'd139, MN_CMPD = 8'd140, MN_LWZ = 8'd141;
  localparam logic [7:0] MN_FDIVS = 8'd165, MN_FSUBS = 8'd166, MN_FADDS = 8'd167;
  localparam logic [7:0] MN_FCMPU = 8'd168, MN_FCMPO = 8'd169;

  // Value select for the result word
  typedef enum logic [1:0] {
    VS_ZERO = 2'd0,
    VS_SEXT = 2'd1,
    VS_ZEXT = 2'd2,
    VS_SPR  = 2'd3
  } vsel_t;

endpackage

>>> rtl/ppcdec_x31.sv
// Extended-opcode decode for primary opcode 31 (combinational).
// Depends on ppcdec_pkg.
module ppcdec_x31 (
  input  logic [31:0] word,
  output logic [7:0]  mn,
  output logic        oe,
  output logic        spr_val
);
  import ppcdec_pkg::*;

  logic [4:0] d, a, b;
  logic       rc, oeb, cmpok;
  logic [9:0] xo1, spr;
  logic [8:0] xo2;
  logic [7:0] spr_off;
  logic [7:0] m2;

  assign d     = word[25:21];
  assign a     = word[20:16];
  assign b     = word[15:11];
  assign rc    = word[0];
  assign oeb   = word[10];
  assign xo1   = word[10:1];
  assign xo2   = word[9:1];
  assign spr   = {b, a};
  assign cmpok = !word[22] && !rc;

  // Named SPR offsets
  always_comb begin
    case (spr)
      10'd1:   spr_off = 8'd0;
      10'd8:   spr_off = 8'd1;
      10'd9:   spr_off = 8'd2;
      10'd18:  spr_off = 8'd3;
      10'd19:  spr_off = 8'd4;
      default: spr_off = 8'd5;
    endcase
  end

  // XO-form arithmetic with OE
  always_comb begin
    case (xo2)
      9'd8:    m2 = 8'd57;
      9'd10:   m2 = 8'd58;
      9'd11:   m2 = oeb ? MN_NONE : 8'd59;
      9'd40:   m2 = 8'd60;
      9'd75:   m2 = oeb ? MN_NONE : 8'd61;
      9'd136:  m2 = 8'd62;
      9'd138:  m2 = 8'd63;
      9'd235:  m2 = 8'd64;
      9'd266:  m2 = 8'd65;
      9'd459:  m2 = 8'd66;
      9'd491:  m2 = 8'd67;
      default: m2 = MN_NONE;
    endcase
  end

  // X-form table
  always_comb begin
    mn      = MN_NONE;
    oe      = 1'b0;
    spr_val = 1'b0;
    if (m2 != MN_NONE) begin
      mn = m2;
      oe = oeb;
    end else begin
      case (xo1)
        XO_DCBZ: mn = (d == 5'd0 && !rc) ? 8'd68 : MN_NONE;
        10'd954: mn = (b == 5'd0) ? 8'd69 : MN_NONE;
        10'd922: mn = (b == 5'd0) ? 8'd70 : MN_NONE;
        10'd918: mn = !rc ? 8'd71 : MN_NONE;
        10'd824: mn = 8'd72;
        10'd792: mn = 8'd73;
        10'd790: mn = !rc ? 8'd74 : MN_NONE;
        10'd695: mn = !rc ? 8'd75 : MN_NONE;
        10'd663: mn = !rc ? 8'd76 : MN_NONE;
        10'd662: mn = !rc ? 8'd77 : MN_NONE;
        10'd661: mn = !rc ? 8'd78 : MN_NONE;
        10'd631: mn = !rc ? 8'd79 : MN_NONE;
        10'd599: mn = !rc ? 8'd80 : MN_NONE;
        10'd597: mn = !rc ? 8'd81 : MN_NONE;
        10'd567: mn = !rc ? 8'd82 : MN_NONE;
        10'd536: mn = 8'd83;
        10'd535: mn = !rc ? 8'd84 : MN_NONE;
        10'd534: mn = !rc ? 8'd85 : MN_NONE;
        10'd476: mn = 8'd86;
        10'd470: mn = (d == 5'd0 && !rc) ? 8'd87 : MN_NONE;
        10'd467: begin
          spr_val = 1'b1;
          mn = !rc ? MN_MTXER + spr_off : MN_NONE;
        end
        10'd444: mn = (d == b) ? MN_MR : MN_OR;
        10'd439: mn = !rc ? 8'd96 : MN_NONE;
        10'd438: mn = !rc ? 8'd97 : MN_NONE;
        10'd412: mn = 8'd98;
        10'd407: mn = !rc ? 8'd99 : MN_NONE;
        10'd375: mn = !rc ? 8'd100 : MN_NONE;
        10'd371: begin
          spr_val = 1'b1;
          if (rc)                 mn = MN_NONE;
          else if (spr == 10'd268) mn = MN_MFTBL;
          else if (spr == 10'd269) mn = MN_MFTBU;
          else                    mn = MN_NONE;
        end
        10'd343: mn = !rc ? 8'd103 : MN_NONE;
        10'd339: begin
          spr_val = 1'b1;
          mn = !rc ? MN_MFXER + spr_off : MN_NONE;
        end
        10'd316: mn = 8'd110;
        10'd311: mn = !rc ? 8'd111 : MN_NONE;
        10'd310: mn = !rc ? 8'd112 : MN_NONE;
        10'd306: mn = (d == 5'd0 && a == 5'd0 && !rc) ? 8'd113 : MN_NONE;
        10'd284: mn = 8'd114;
        10'd279: mn = !rc ? 8'd115 : MN_NONE;
        10'd278: mn = (d == 5'd0 && !rc) ? 8'd116 : MN_NONE;
        10'd247: mn = !rc ? 8'd117 : MN_NONE;
        10'd246: mn = (d == 5'd0 && !rc) ? 8'd118 : MN_NONE;
        10'd242: mn = (a == 5'd0 && !rc) ? 8'd119 : MN_NONE;
        10'd215: mn = !rc ? 8'd120 : MN_NONE;
        10'd183: mn = !rc ? 8'd121 : MN_NONE;
        10'd151: mn = !rc ? 8'd122 : MN_NONE;
        10'd150: mn = rc ? 8'd123 : MN_NONE;
        10'd124: mn = (d == b) ? MN_NOT : MN_NOR;
        10'd119: mn = !rc ? 8'd126 : MN_NONE;
        10'd87:  mn = !rc ? 8'd127 : MN_NONE;
        10'd86:  mn = (d == 5'd0 && !rc) ? 8'd128 : MN_NONE;
        10'd60:  mn = 8'd129;
        10'd55:  mn = !rc ? 8'd130 : MN_NONE;
        10'd54:  mn = (d == 5'd0 && !rc) ? 8'd131 : MN_NONE;
        10'd32:  mn = cmpok ? (word[21] ? MN_CMPLD : MN_CMPLW) : MN_NONE;
        10'd28:  mn = 8'd134;
        10'd26:  mn = (b == 5'd0) ? 8'd135 : MN_NONE;
        10'd24:  mn = 8'd136;
        10'd23:  mn = !rc ? 8'd137 : MN_NONE;
        10'd20:  mn = !rc ? 8'd138 : MN_NONE;
        10'd0:   mn = cmpok ? (word[21] ? MN_CMPD : MN_CMPW) : MN_NONE;
        default: mn = MN_NONE;
      endcase
    end
  end
endmodule

>>> rtl/ppcdec_core.sv
// Full single-word decode: primary opcodes, aliases, flags and value.
// Depends on ppcdec_pkg and ppcdec_x31.
module ppcdec_core (
  input  ppcdec_pkg::in_item_t  item,
  output ppcdec_pkg::out_item_t res
);
  import ppcdec_pkg::*;

  logic [31:0] w, addr, sext, bdisp, idisp, tgt;
  logic [5:0]  op;
  logic [4:0]  d, a, b, c, e;
  logic [9:0]  xo1;
  logic        rc, aa, b9, lbit;
  logic [7:0]  mn, x_mn;
  logic        x_oe, x_spr;
  logic        illegal, f_rc, f_oe, f_lk, f_aa, use_tgt;
  vsel_t       vsel;

  assign w    = item.instr_word;
  assign addr = item.instr_address;
  assign op   = w[31:26];
  assign d    = w[25:21];
  assign a    = w[20:16];
  assign b    = w[15:11];
  assign c    = w[10:6];
  assign e    = w[5:1];
  assign xo1  = w[10:1];
  assign rc   = w[0];
  assign aa   = w[1];
  assign b9   = w[22];
  assign lbit = w[21];
  assign sext = {{16{w[15]}}, w[15:0]};

  // Branch displacements and target adder
  assign bdisp = {sext[31:2], 2'b00};
  assign idisp = {{6{w[25]}}, w[25:2], 2'b00};
  assign tgt   = aa ? ((op == 6'd16) ? bdisp : idisp)
                    : addr + ((op == 6'd16) ? bdisp : idisp);

  ppcdec_x31 u_x31 (
    .word    (w),
    .mn      (x_mn),
    .oe      (x_oe),
    .spr_val (x_spr)
  );

  // Primary opcode classification
  always_comb begin
    illegal = 1'b0;
    mn      = MN_NONE;
    f_rc    = 1'b0;
    f_oe    = 1'b0;
    f_lk    = 1'b0;
    f_aa    = 1'b0;
    use_tgt = 1'b0;
    vsel    = VS_ZERO;
    case (op)
      6'd1, 6'd2, 6'd5, 6'd6, 6'd9, 6'd22, 6'd30, 6'd58, 6'd62: illegal = 1'b1;
      6'd3: begin mn = MN_TWI; vsel = VS_SEXT; end
      6'd4: mn = (d == 5'd0 && xo1 == XO_DCBZ && !rc) ? MN_DCBZ_L : MN_NONE;
      6'd7: begin mn = MN_MULLI; vsel = VS_SEXT; end
      6'd8: begin mn = MN_SUBFIC; vsel = VS_SEXT; end
      6'd10: if (!b9) begin
        mn = lbit ? MN_CMPLDI : MN_CMPLWI;
        vsel = VS_ZEXT;
      end
      6'd11: if (!b9) begin
        mn = lbit ? MN_CMPDI : MN_CMPWI;
        vsel = VS_SEXT;
      end
      6'd17: mn = (w == W_SC) ? MN_SC : MN_NONE;
      6'd12, 6'd13, 6'd14, 6'd15: begin
        vsel = VS_SEXT;
        if (op == 6'd14 && a == 5'd0)      mn = MN_LI;
        else if (op == 6'd15 && a == 5'd0) mn = MN_LIS;
        else mn = (w[15] ? MN_SUBIC : MN_ADDIC) + {6'd0, op[1:0]};
      end
      6'd16: begin
        use_tgt = 1'b1;
        f_lk = rc;
        f_aa = aa;
        if (d == 5'd4)       mn = MN_BGE + {6'd0, a[1:0]};
        else if (d == 5'd12) mn = MN_BLT + {6'd0, a[1:0]};
        else                 mn = MN_BC;
      end
      6'd18: begin
        use_tgt = 1'b1;
        f_lk = rc;
        f_aa = aa;
        mn = MN_B;
      end
      6'd19: begin
        if (w == W_RFI)        mn = MN_RFI;
        else if (w == W_ISYNC) mn = MN_ISYNC;
        else if (w == W_BLR)   mn = MN_BLR;
        else if (w == W_BLRL) begin mn = MN_BLRL; f_lk = 1'b1; end
        else if (w == W_BCTR)  mn = MN_BCTR;
        else if (w == W_BCTRL) begin mn = MN_BCTRL; f_lk = 1'b1; end
        else if (!rc) begin
          case (xo1)
            10'd33:  mn = MN_CRNOR;
            10'd129: mn = MN_CRANDC;
            10'd193: mn = (a == b) ? MN_CRCLR : MN_CRXOR;
            10'd225: mn = MN_CRNAND;
            10'd257: mn = MN_CRAND;
            10'd289: mn = MN_CREQV;
            10'd417: mn = MN_CRORC;
            10'd449: mn = MN_CROR;
            default: mn = MN_NONE;
          endcase
        end
      end
      6'd20, 6'd21: begin
        f_rc = rc;
        mn = MN_RLWIMI + {7'd0, op[0]};
      end
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29: begin
        vsel = VS_ZEXT;
        if (w == W_NOP) mn = MN_NOP;
        else begin
          f_rc = (op >= 6'd28);
          mn = MN_ORI + {2'd0, op - 6'd24};
        end
      end
      6'd31: begin
        if (w == W_TLBSYNC)    mn = MN_TLBSYNC;
        else if (w == W_SYNC)  mn = MN_SYNC;
        else if (w == W_EIEIO) mn = MN_EIEIO;
        else begin
          f_rc = rc;
          f_oe = x_oe;
          mn = x_mn;
          vsel = x_spr ? VS_SPR : VS_ZERO;
        end
      end
      6'd59: begin
        f_rc = rc;
        if (c == 5'd0) begin
          if (e == 5'd18)      mn = MN_FDIVS;
          else if (e == 5'd20) mn = MN_FSUBS;
          else if (e == 5'd21) mn = MN_FADDS;
        end
      end
      6'd63: if (!b9 && !rc) begin
        if (xo1 == 10'd0)       mn = MN_FCMPU;
        else if (xo1 == 10'd32) mn = MN_FCMPO;
      end
      default: if (op >= 6'd32 && op <= 6'd55) begin
        vsel = VS_SEXT;
        mn = MN_LWZ + {2'd0, op - 6'd32};
      end
    endcase
  end

  // Result assembly; flags and value cleared when not decoded
  always_comb begin
    res.field_d = d;
    res.field_a = a;
    res.field_b = b;
    res.field_c = c;
    res.field_e = e;
    if (illegal || mn == MN_NONE) begin
      res.status        = illegal ? ST_ILLEGAL : ST_UNKNOWN;
      res.mnemonic      = MN_NONE;
      res.record_flag   = 1'b0;
      res.overflow_flag = 1'b0;
      res.link_flag     = 1'b0;
      res.absolute_flag = 1'b0;
      res.value         = 32'd0;
    end else begin
      res.status        = ST_OK;
      res.mnemonic      = mn;
      res.record_flag   = f_rc;
      res.overflow_flag = f_oe;
      res.link_flag     = f_lk;
      res.absolute_flag = f_aa;
      if (use_tgt) res.value = tgt;
      else begin
        case (vsel)
          VS_SEXT: res.value = sext;
          VS_ZEXT: res.value = {16'd0, w[15:0]};
          VS_SPR:  res.value = {22'd0, b, a};
          default: res.value = 32'd0;
        endcase
      end
    end
  end
endmodule

>>> rtl/ppc_instruction_decoder.sv
// Top level of the PowerPC instruction decoder: input register, decode,
// result register. Depends on ppcdec_pkg and ppcdec_core.
//
// Decodes one 32-bit PowerPC word per cycle while out_ready does not stall
// the output. A transaction is registered on input, decoded by one pass of
// combinational logic, and the result is registered for output. The path
// is set by the opcode tables and the 32-bit branch target adder. Input
// ready stays high while the input register is empty or the result stage
// is empty or being drained.
module ppc_instruction_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ppcdec_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ppcdec_pkg::out_item_t out_data
);
  import ppcdec_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t dec;
  logic      stage_ready, out_take;

  // Stages advance when the result register is free or being taken
  assign out_take    = !out_valid || out_ready;
  assign stage_ready = !in_vld_r || out_take;
  assign in_ready    = stage_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (stage_ready) begin
      in_vld_r <= in_valid;
    end
    if (stage_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  ppcdec_core u_core (
    .item (in_r),
    .res  (dec)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= in_vld_r;
    end
    if (out_take && in_vld_r) begin
      out_data <= dec;
    end
  end
endmodule
